// ----- rtl/opu_pkg.sv -----
// Shared types, constants and tables for the orbit position update block.
// Used by opu_turn, opu_cordic, opu_qmul and orbit_position_update.
// No dependencies.
package opu_pkg;

  // Fixed-point scale of angles (degrees) and radius (units).
  localparam int FRAC_BITS = 7;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int TIME_W  = 16;
  localparam int RATE_W  = 10;
  localparam int POS_W   = 15;
  localparam int YAW_W   = 16;
  localparam int PITCH_W = 15;
  localparam int RAD_W   = 14;
  localparam int STEP_W  = 14;
  localparam int PROD_W  = TIME_W + RATE_W;
  localparam int STEP_SH = 16 - FRAC_BITS;

  localparam int ANG_FULL  = 360 << FRAC_BITS;
  localparam int PITCH_LIM = 89 << FRAC_BITS;
  localparam int RAD_MIN   = 1 << FRAC_BITS;
  localparam int RAD_MAX   = 90 << FRAC_BITS;
  localparam int STEP_MAX  = 90 << FRAC_BITS;
  localparam int OUT_LIM   = 90 << FRAC_BITS;

  localparam int YAW_RST   = 15 << (FRAC_BITS - 1);
  localparam int PITCH_RST = 15 << FRAC_BITS;
  localparam int RAD_RST   = 15 << FRAC_BITS;
  localparam int RATE_RST  = 90;

  // Degrees to binary angle: a * 2^(32-FRAC_BITS) / 360 = a * 2^TURN_SH / 45.
  localparam int TURN_DIV   = 45;
  localparam int TURN_SH    = 32 - FRAC_BITS - 3;
  localparam int TURN_RECIP = 93207;   // ceil(2^22 / 45), exact for 16-bit a
  localparam int TURN_RA_W  = $clog2(TURN_DIV);
  localparam int TURN_QA_W  = 11;
  localparam int TURN_ANG_W = 17;

  typedef logic [TURN_SH-1:0] turn_frac_t [TURN_DIV];

  function automatic turn_frac_t build_turn_frac();
    turn_frac_t t;
    for (int i = 0; i < TURN_DIV; i++) begin
      t[i] = TURN_SH'((longint'(i) << TURN_SH) / TURN_DIV);
    end
    return t;
  endfunction

  // floor(i * 2^TURN_SH / 45) for the remainder of a / 45
  localparam turn_frac_t TURN_FRAC = build_turn_frac();

  // CORDIC
  localparam int CORDIC_W   = 34;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

  typedef logic signed [CORDIC_W-1:0] trig_t;

  localparam trig_t GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Q30 multiplier operands and result
  localparam int MUL_A_W = 16;
  localparam int MUL_P_W = MUL_A_W + CORDIC_W;
  localparam int MUL_R_W = MUL_P_W - 30;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_R_W-1:0] mul_r_t;
  typedef logic signed [POS_W-1:0]   pos_t;

  function automatic pos_t sat_pos(mul_r_t v);
    pos_t r;
    if (v > mul_r_t'(OUT_LIM)) begin
      r = pos_t'(OUT_LIM);
    end else if (v < -mul_r_t'(OUT_LIM)) begin
      r = pos_t'(-OUT_LIM);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/orbit_position_update.sv -----
// Orbit position update top level: state update, sequencer, output register.
// Depends on opu_pkg, opu_turn, opu_cordic, opu_qmul.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  cfg     | in        | cfg_valid_i/ready_o  | turn_rate_i
//  in      | in        | in_valid_i/stall_o   | go_*_i, zoom_*_i, time_step_i
//  out     | out       | out_valid_o/stall_i  | pos_x_o, pos_y_o, pos_z_o
//
// Each transaction runs the single CORDIC unit once for pitch and once for yaw, then
// makes four passes through the shared multiplier. in_stall_o is high while a
// transaction is being worked on. A finished result sits in the output register;
// the next input is taken while it waits. Reset is asynchronous, active low, and
// needs no clearing pass.
module orbit_position_update #(
  parameter int CORDIC_STEPS = opu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [opu_pkg::RATE_W-1:0]   turn_rate_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         go_left_i,
  input  logic                         go_right_i,
  input  logic                         go_up_i,
  input  logic                         go_down_i,
  input  logic                         zoom_closer_i,
  input  logic                         zoom_farther_i,
  input  logic [opu_pkg::TIME_W-1:0]   time_step_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [opu_pkg::POS_W-1:0] pos_x_o,
  output logic signed [opu_pkg::POS_W-1:0] pos_y_o,
  output logic signed [opu_pkg::POS_W-1:0] pos_z_o
);
  import opu_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_STEP   = 4'd1;
  localparam logic [3:0] ST_UPD    = 4'd2;
  localparam logic [3:0] ST_ANG_P  = 4'd3;
  localparam logic [3:0] ST_WAIT_P = 4'd4;
  localparam logic [3:0] ST_ANG_Y  = 4'd5;
  localparam logic [3:0] ST_WAIT_Y = 4'd6;
  localparam logic [3:0] ST_MUL_T  = 4'd7;
  localparam logic [3:0] ST_MUL_X  = 4'd8;
  localparam logic [3:0] ST_MUL_Y  = 4'd9;
  localparam logic [3:0] ST_MUL_Z  = 4'd10;
  localparam logic [3:0] ST_MUL_W  = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  localparam int YW_W = YAW_W + 2;
  localparam int PT_W = PITCH_W + 2;
  localparam int RD_W = RAD_W + 3;

  logic [3:0] state_q, state_d;

  logic [RATE_W-1:0]         rate_q;
  logic [YAW_W-1:0]          yaw_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic [RAD_W-1:0]          rad_q;
  logic                      out_valid_q;

  logic [5:0]        dir_q;
  logic [PROD_W-1:0] prod_q;
  logic [STEP_W-1:0] step_q;
  trig_t             cp_q, sp_q, cy_q, sy_q;
  mul_a_t            t_q;
  pos_t              x_q, y_q, z_q, pos_x_q, pos_y_q, pos_z_q;

  logic in_acc, out_acc, out_load;
  logic [PROD_W-STEP_SH-1:0] step_raw;

  logic signed [YW_W-1:0] yw, yw_n;
  logic signed [PT_W-1:0] pt, pt_n;
  logic signed [RD_W-1:0] rd, rd_n;

  logic                         turn_start, turn_done;
  logic signed [TURN_ANG_W-1:0] turn_ang;
  logic [31:0]                  turn_val;
  logic                         cor_done;
  trig_t                        cor_cos, cor_sin;
  mul_a_t                       mul_a;
  trig_t                        mul_b;
  mul_r_t                       mul_p;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  assign step_raw = prod_q[PROD_W-1:STEP_SH];

  // Move, then wrap yaw and clamp pitch and radius
  always_comb begin
    yw = YW_W'(yaw_q);
    pt = PT_W'(pitch_q);
    rd = RD_W'(rad_q);
    if (dir_q[0]) yw = yw + YW_W'(step_q);
    if (dir_q[1]) yw = yw - YW_W'(step_q);
    if (dir_q[2]) pt = pt + PT_W'(step_q);
    if (dir_q[3]) pt = pt - PT_W'(step_q);
    if (dir_q[4]) rd = rd - RD_W'(step_q);
    if (dir_q[5]) rd = rd + RD_W'(step_q);

    priority if (yw > YW_W'(ANG_FULL)) yw_n = YW_W'(step_q);
    else if (yw < 0)                   yw_n = YW_W'(ANG_FULL) - YW_W'(step_q);
    else                               yw_n = yw;

    priority if (pt > PT_W'(PITCH_LIM)) pt_n = PT_W'(PITCH_LIM);
    else if (pt < -PT_W'(PITCH_LIM))    pt_n = -PT_W'(PITCH_LIM);
    else                                pt_n = pt;

    priority if (rd < RD_W'(RAD_MIN)) rd_n = RD_W'(RAD_MIN);
    else if (rd > RD_W'(RAD_MAX))     rd_n = RD_W'(RAD_MAX);
    else                              rd_n = rd;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_STEP;
      ST_STEP:   state_d = ST_UPD;
      ST_UPD:    state_d = ST_ANG_P;
      ST_ANG_P:  state_d = ST_WAIT_P;
      ST_WAIT_P: if (cor_done) state_d = ST_ANG_Y;
      ST_ANG_Y:  state_d = ST_WAIT_Y;
      ST_WAIT_Y: if (cor_done) state_d = ST_MUL_T;
      ST_MUL_T:  state_d = ST_MUL_X;
      ST_MUL_X:  state_d = ST_MUL_Y;
      ST_MUL_Y:  state_d = ST_MUL_Z;
      ST_MUL_Z:  state_d = ST_MUL_W;
      ST_MUL_W:  state_d = ST_FIN;
      ST_FIN:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign turn_start = (state_q == ST_ANG_P) || (state_q == ST_ANG_Y);
  assign turn_ang   = (state_q == ST_ANG_P) ? TURN_ANG_W'(pitch_q)
                                            : TURN_ANG_W'({1'b0, yaw_q});

  // Multiplier operand select; the result is registered and lands in the next cycle
  always_comb begin
    mul_a = mul_a_t'({2'b00, rad_q});
    mul_b = cp_q;
    unique case (state_q)
      ST_MUL_X: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = cy_q;
      end
      ST_MUL_Y: begin
        mul_b = sp_q;
      end
      ST_MUL_Z: begin
        mul_a = t_q;
        mul_b = sy_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_W'(RATE_RST);
      yaw_q       <= YAW_W'(YAW_RST);
      pitch_q     <= PITCH_W'(PITCH_RST);
      rad_q       <= RAD_W'(RAD_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) rate_q <= turn_rate_i;
      if (state_q == ST_UPD) begin
        yaw_q   <= yw_n[YAW_W-1:0];
        pitch_q <= pt_n[PITCH_W-1:0];
        rad_q   <= rd_n[RAD_W-1:0];
      end
      if (out_load)     out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dir_q  <= {zoom_farther_i, zoom_closer_i, go_down_i, go_up_i, go_right_i, go_left_i};
      prod_q <= PROD_W'(time_step_i) * PROD_W'(rate_q);
    end
    if (state_q == ST_STEP) begin
      step_q <= (step_raw > (PROD_W-STEP_SH)'(STEP_MAX)) ? STEP_W'(STEP_MAX)
                                                         : step_raw[STEP_W-1:0];
    end
    if (state_q == ST_WAIT_P && cor_done) begin
      cp_q <= cor_cos;
      sp_q <= cor_sin;
    end
    if (state_q == ST_WAIT_Y && cor_done) begin
      cy_q <= cor_cos;
      sy_q <= cor_sin;
    end
    if (state_q == ST_MUL_X) t_q <= mul_p[MUL_A_W-1:0];
    if (state_q == ST_MUL_Y) x_q <= sat_pos(mul_p);
    if (state_q == ST_MUL_Z) y_q <= sat_pos(mul_p);
    if (state_q == ST_MUL_W) z_q <= sat_pos(mul_p);
    if (out_load) begin
      pos_x_q <= x_q;
      pos_y_q <= y_q;
      pos_z_q <= z_q;
    end
  end

  opu_turn u_turn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (turn_start),
    .ang_i   (turn_ang),
    .done_o  (turn_done),
    .turn_o  (turn_val)
  );

  opu_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (turn_done),
    .theta_i (turn_val),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  opu_qmul u_qmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;

endmodule

// ----- rtl/opu_turn.sv -----
// Degree-to-binary-angle converter: three register stages, truncation toward zero.
// Depends on opu_pkg.
module opu_turn (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [opu_pkg::TURN_ANG_W-1:0] ang_i,
  output logic                               done_o,
  output logic [31:0]                        turn_o
);
  import opu_pkg::*;

  localparam int ABS_W = TURN_ANG_W - 1;
  localparam int MP_W  = ABS_W + 17;

  logic             v1_q, v2_q, done_q;
  logic [ABS_W-1:0] a1_q, a2_q;
  logic             neg1_q, neg2_q;
  logic [TURN_QA_W-1:0] qa_q;
  logic [31:0]      turn_q;

  logic [MP_W-1:0]      mprod;
  logic [ABS_W:0]       rem_full;
  logic [TURN_RA_W-1:0] ra;
  logic [31:0]          turn_pos;
  logic [ABS_W-1:0]     a_abs;

  assign a_abs    = ang_i[TURN_ANG_W-1] ? ABS_W'(-ang_i) : ABS_W'(ang_i);
  assign mprod    = MP_W'(a1_q) * MP_W'(TURN_RECIP);
  assign rem_full = (ABS_W+1)'(a2_q) - ((ABS_W+1)'(qa_q) * (ABS_W+1)'(TURN_DIV));
  assign ra       = rem_full[TURN_RA_W-1:0];
  assign turn_pos = 32'({qa_q, {TURN_SH{1'b0}}}) + 32'(TURN_FRAC[ra]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a1_q   <= a_abs;
      neg1_q <= ang_i[TURN_ANG_W-1];
    end
    if (v1_q) begin
      a2_q   <= a1_q;
      neg2_q <= neg1_q;
      qa_q   <= mprod[TURN_SH +: TURN_QA_W];
    end
    if (v2_q) begin
      turn_q <= neg2_q ? -turn_pos : turn_pos;
    end
  end

  assign done_o = done_q;
  assign turn_o = turn_q;

endmodule

// ----- rtl/opu_cordic.sv -----
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on a shared shifter.
// Depends on opu_pkg.
module opu_cordic #(
  parameter int CORDIC_STEPS = opu_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         theta_i,
  output logic                done_o,
  output opu_pkg::trig_t      cos_o,
  output opu_pkg::trig_t      sin_o
);
  import opu_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic             busy_q, done_q, flip_q;
  logic [CNT_W-1:0] cnt_q;
  trig_t            x_q, y_q, z_q;
  trig_t            x_d, y_d, z_d;
  trig_t            cos_q, sin_q;
  trig_t            dx, dy, dz;
  logic             flip;
  logic             last;

  assign flip = theta_i[31] ^ theta_i[30];
  assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
  assign dx   = y_q >>> cnt_q;
  assign dy   = x_q >>> cnt_q;
  assign dz   = trig_t'({{(CORDIC_W-32){1'b0}}, ATAN_TURN[ATAN_IDX_W'(cnt_q)]});

  always_comb begin
    if (!z_q[CORDIC_W-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - dz;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip;
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      // quadrants 2/3 rotated by half a turn
      z_q    <= trig_t'($signed({theta_i[31] ^ flip, theta_i[30:0]}));
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (last) begin
        cos_q <= flip_q ? -x_d : x_d;
        sin_q <= flip_q ? -y_d : y_d;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

// ----- rtl/opu_qmul.sv -----
// Shared Q30 multiplier with round-half-up and registered result.
// Depends on opu_pkg.
module opu_qmul (
  input  logic            clk_i,
  input  opu_pkg::mul_a_t a_i,
  input  opu_pkg::trig_t  b_i,
  output opu_pkg::mul_r_t p_o
);
  import opu_pkg::*;

  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] rnd;
  mul_r_t                    p_q;

  assign prod = MUL_P_W'(a_i) * MUL_P_W'(b_i);
  assign rnd  = prod + (MUL_P_W'(1) <<< 29);

  always_ff @(posedge clk_i) begin
    p_q <= rnd[MUL_P_W-1:30];
  end

  assign p_o = p_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for orbit_position_update: drives ticks and turn_rate writes,
// predicts each camera position and compares it field by field with the block's output.
// Depends on opu_pkg and the orbit_position_update RTL.
module tb_top;
  import opu_pkg::*;

  localparam int NUM_ROTATIONS = (CORDIC_STEPS_DEF < ATAN_LEN) ? CORDIC_STEPS_DEF : ATAN_LEN;
  localparam int PHASE_TICKS   = 145;
  localparam int NUM_PHASES    = 10;
  localparam int MAX_GAP       = 70;

  localparam logic [5:0] DIR_LEFT    = 6'b000001;
  localparam logic [5:0] DIR_RIGHT   = 6'b000010;
  localparam logic [5:0] DIR_UP      = 6'b000100;
  localparam logic [5:0] DIR_DOWN    = 6'b001000;
  localparam logic [5:0] DIR_CLOSER  = 6'b010000;
  localparam logic [5:0] DIR_FARTHER = 6'b100000;
  localparam logic [5:0] DIR_ALL     = 6'b111111;

  typedef struct packed {
    logic [5:0]        dirs;
    logic [TIME_W-1:0] dt;
  } tick_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } position_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [RATE_W-1:0] turn_rate_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              go_left_i      = 1'b0;
  logic              go_right_i     = 1'b0;
  logic              go_up_i        = 1'b0;
  logic              go_down_i      = 1'b0;
  logic              zoom_closer_i  = 1'b0;
  logic              zoom_farther_i = 1'b0;
  logic [TIME_W-1:0] time_step_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  pos_t              pos_x_o;
  pos_t              pos_y_o;
  pos_t              pos_z_o;

  // camera state as the block should hold it
  logic [RATE_W-1:0] rate_q   = RATE_W'(RATE_RST);
  longint            yaw_q    = YAW_RST;
  longint            pitch_q  = PITCH_RST;
  longint            radius_q = RAD_RST;

  position_t pending_positions[$];
  position_t want_pos;
  int        mismatches = 0;
  bit        calm       = 1'b0;
  int        stall_left = 0;

  orbit_position_update i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .turn_rate_i    (turn_rate_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .go_left_i      (go_left_i),
    .go_right_i     (go_right_i),
    .go_up_i        (go_up_i),
    .go_down_i      (go_down_i),
    .zoom_closer_i  (zoom_closer_i),
    .zoom_farther_i (zoom_farther_i),
    .time_step_i    (time_step_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint q30_round(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  // degrees (FRAC_BITS fraction) to binary angle, 2^32 per turn, truncated toward zero
  function automatic logic [31:0] deg_to_turn(longint deg);
    longint t;
    t = (deg * (longint'(1) << (32 - FRAC_BITS))) / 360;
    return t[31:0];
  endfunction

  task automatic cordic_sincos(input logic [31:0] theta, output longint c, output longint s);
    logic      flip;
    logic [31:0] th;
    longint    x, y, z, dx, dy;
    // second and third quadrant: rotate by half a turn, negate at the end
    flip = (theta >= 32'h4000_0000) && (theta < 32'hC000_0000);
    th = flip ? theta + 32'h8000_0000 : theta;
    z = longint'($signed(th));
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < NUM_ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURN[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic pos_t clamp_pos(longint v);
    if (v > OUT_LIM) begin
      v = OUT_LIM;
    end else if (v < -OUT_LIM) begin
      v = -OUT_LIM;
    end
    return pos_t'(v);
  endfunction

  task automatic advance_camera(input tick_t t, output position_t p);
    longint step, yw, pt, rd, cp, sp, cy, sy, tr;
    step = (longint'(t.dt) * longint'(rate_q)) >>> STEP_SH;
    if (step > STEP_MAX) step = STEP_MAX;
    yw = yaw_q;
    pt = pitch_q;
    rd = radius_q;
    if (|(t.dirs & DIR_LEFT))    yw += step;
    if (|(t.dirs & DIR_RIGHT))   yw -= step;
    if (|(t.dirs & DIR_UP))      pt += step;
    if (|(t.dirs & DIR_DOWN))    pt -= step;
    if (|(t.dirs & DIR_CLOSER))  rd -= step;
    if (|(t.dirs & DIR_FARTHER)) rd += step;
    // yaw does not wrap modulo a turn: it restarts from the step
    if (yw > ANG_FULL) begin
      yw = step;
    end else if (yw < 0) begin
      yw = ANG_FULL - step;
    end
    if (pt > PITCH_LIM) begin
      pt = PITCH_LIM;
    end else if (pt < -PITCH_LIM) begin
      pt = -PITCH_LIM;
    end
    if (rd < RAD_MIN) begin
      rd = RAD_MIN;
    end else if (rd > RAD_MAX) begin
      rd = RAD_MAX;
    end
    yaw_q = yw;
    pitch_q = pt;
    radius_q = rd;
    cordic_sincos(deg_to_turn(pt), cp, sp);
    cordic_sincos(deg_to_turn(yw), cy, sy);
    tr = q30_round(rd, cp);
    p.x = clamp_pos(q30_round(tr, cy));
    p.y = clamp_pos(q30_round(rd, sp));
    p.z = clamp_pos(q30_round(tr, sy));
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (calm) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 19) begin
      out_stall_i <= 1'b1;
      // now and then a long hold so that a finished result waits
      if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(10, 70);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected position (%0d,%0d,%0d)", pos_x_o, pos_y_o, pos_z_o);
        end
        mismatches++;
      end else begin
        want_pos = pending_positions.pop_front();
        if (pos_x_o !== want_pos.x || pos_y_o !== want_pos.y || pos_z_o !== want_pos.z) begin
          if (mismatches < 10) begin
            $display("position mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     want_pos.x, want_pos.y, want_pos.z, pos_x_o, pos_y_o, pos_z_o);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_tick(tick_t t);
    position_t p;
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    go_left_i      <= |(t.dirs & DIR_LEFT);
    go_right_i     <= |(t.dirs & DIR_RIGHT);
    go_up_i        <= |(t.dirs & DIR_UP);
    go_down_i      <= |(t.dirs & DIR_DOWN);
    zoom_closer_i  <= |(t.dirs & DIR_CLOSER);
    zoom_farther_i <= |(t.dirs & DIR_FARTHER);
    time_step_i    <= t.dt;
    do @(posedge clk_i); while (in_stall_o);
    advance_camera(t, p);
    pending_positions.push_back(p);
  endtask

  function automatic tick_t make_tick(logic [5:0] dirs, logic [TIME_W-1:0] dt);
    tick_t t;
    t.dirs = dirs;
    t.dt = dt;
    return t;
  endfunction

  function automatic tick_t random_tick();
    logic [TIME_W-1:0] dt;
    case ($urandom_range(0, 3))
      0: dt = TIME_W'($urandom_range(0, 255));
      1: dt = TIME_W'($urandom_range(0, 4095));
      2: dt = TIME_W'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: dt = '0;
          1: dt = TIME_W'(1);
          default: dt = '1;
        endcase
      end
    endcase
    return make_tick(6'($urandom_range(0, 63)), dt);
  endfunction

  // sender holds off until every pending position has come out
  task automatic drain_positions();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_positions.size() != 0);
  endtask

  task automatic write_turn_rate(logic [RATE_W-1:0] rate);
    cfg_valid_i <= 1'b1;
    turn_rate_i <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rate_q = rate;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    send_tick(make_tick('0, '0));
    send_tick(make_tick(DIR_LEFT, 16'd1024));   // step 180 at the reset rate
    drain_positions();
  endtask

  // at rate 512 the step equals time_step, so exact limits can be hit
  task automatic test_clamps_and_wrap();
    write_turn_rate(10'd512);
    send_tick(make_tick(DIR_FARTHER, 16'd11520));
    send_tick(make_tick(DIR_DOWN, 16'd1920));
    send_tick(make_tick(DIR_RIGHT, 16'd960));   // yaw 180 raw (1.40625), pitch 0, radius 90: overshoot
    send_tick(make_tick(DIR_RIGHT, 16'd1));     // yaw 179 raw, still above zero
    send_tick(make_tick(DIR_LEFT, 16'd1));      // yaw back to 180 raw, well below a full turn
    send_tick(make_tick(DIR_LEFT, 16'd1));      // yaw 181 raw, still below a full turn
    send_tick(make_tick(DIR_LEFT | DIR_RIGHT, 16'hFFFF));
    send_tick(make_tick(DIR_UP, 16'hFFFF));
    send_tick(make_tick(DIR_UP | DIR_DOWN | DIR_CLOSER | DIR_FARTHER, 16'd300));
    send_tick(make_tick(DIR_DOWN, 16'hFFFF));
    send_tick(make_tick(DIR_DOWN, 16'hFFFF));
    send_tick(make_tick(DIR_CLOSER, 16'hFFFF));
    send_tick(make_tick(DIR_CLOSER, 16'd1));
    send_tick(make_tick(DIR_ALL, 16'hFFFF));
    drain_positions();
  endtask

  task automatic test_step_limits();
    write_turn_rate('1);
    send_tick(make_tick(DIR_LEFT | DIR_UP | DIR_FARTHER, 16'hFFFF));
    send_tick(make_tick(DIR_RIGHT | DIR_DOWN, 16'hFFFF));
    drain_positions();
    write_turn_rate('0);
    send_tick(make_tick(DIR_LEFT | DIR_UP | DIR_CLOSER, 16'hFFFF));
    drain_positions();
    write_turn_rate(10'd1);
    send_tick(make_tick(DIR_LEFT | DIR_FARTHER, 16'hFFFF));
    send_tick(make_tick(DIR_RIGHT | DIR_DOWN, 16'h5555));
    drain_positions();
  endtask

  task automatic test_random_phases();
    logic [RATE_W-1:0] rate;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: rate = '0;
        1: rate = '1;
        2: rate = RATE_W'(RATE_RST);
        3: rate = 10'd512;
        default: rate = RATE_W'($urandom_range(1, 1023));
      endcase
      write_turn_rate(rate);
      calm = (ph == 5);
      repeat (PHASE_TICKS) send_tick(random_tick());
      drain_positions();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_values();
    test_clamps_and_wrap();
    test_step_limits();
    test_random_phases();
    drain_positions();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/opu_pkg.sv
rtl/opu_turn.sv
rtl/opu_cordic.sv
rtl/opu_qmul.sv
rtl/orbit_position_update.sv
tb/sv/tb_top.sv
